### sv/tpc_pkg.sv
// Shared types, widths and register codes of the triangle plane clipper.
package tpc_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_W     = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = COORD_BITS + 33;
    localparam int DIST_W     = COORD_BITS + 35;
    localparam int REM_W      = DIST_W + 1;
    localparam int LERP_W     = DIFF_W + FRAC_W;
    localparam int DIV_STEPS  = FRAC_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NZ = 3'd5;

    localparam logic [31:0] NZ_RESET = 32'h0001_0000;

    // number of vertices on the inside of the plane
    localparam logic [1:0] IN_NONE = 2'd0;
    localparam logic [1:0] IN_ONE  = 2'd1;
    localparam logic [1:0] IN_TWO  = 2'd2;
    localparam logic [1:0] IN_ALL  = 2'd3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [2:0][COORD_BITS-1:0] t_vec;
    typedef t_vec [2:0] t_verts;
    typedef logic [2:0][31:0] t_vec32;

    typedef struct packed {
        logic        valid;
        t_verts      verts;
        logic [31:0] fill;
        logic [31:0] line;
    } t_dist_in;

    typedef struct packed {
        logic                   valid;
        t_verts                 verts;
        logic [2:0][DIST_W-1:0] dval;
        logic [31:0]            fill;
        logic [31:0]            line;
    } t_dist_out;

    typedef struct packed {
        logic [1:0]             ni;
        t_vec                   p0;
        t_vec                   p1;
        t_vec                   p2;
        t_vec                   a0;
        t_vec                   a1;
        logic [2:0][DIFF_W-1:0] mag0;
        logic [2:0][DIFF_W-1:0] mag1;
        logic [2:0]             neg0;
        logic [2:0]             neg1;
        logic [31:0]            fill;
        logic [31:0]            line;
    } t_job;

    typedef struct packed {
        logic [DIST_W-1:0] rem;
        logic [DIST_W-1:0] den;
        logic [FRAC_W-1:0] q;
    } t_div;

    typedef struct packed {
        logic valid;
        t_job job;
        t_div d0;
        t_div d1;
    } t_dpipe;

    typedef struct packed {
        logic        valid;
        logic [1:0]  ni;
        t_vec32      p0;
        t_vec32      p1;
        t_vec32      p2;
        t_vec32      x0;
        t_vec32      x1;
        logic [31:0] fill;
        logic [31:0] line;
    } t_res;

    function automatic t_coord ext_coord(input logic [31:0] v);
        return t_coord'($signed(v));
    endfunction

endpackage

### sv/tpc_dist.sv
// Signed plane distance of three vertices: difference, multiply, sum stages.
module tpc_dist (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tpc_pkg::t_dist_in   i_item,
    input  tpc_pkg::t_vec       i_p,
    input  tpc_pkg::t_vec32     i_n,
    output tpc_pkg::t_dist_out  o_item
);

    tpc_pkg::t_dist_in r_s1;
    tpc_pkg::t_dist_in r_s2;
    logic signed [tpc_pkg::DIFF_W-1:0] r_diff [3][3];
    logic signed [tpc_pkg::PROD_W-1:0] r_prod [3][3];
    tpc_pkg::t_dist_out r_s3;

    // stage 1: vertex minus plane point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= i_item;
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    r_diff[v][k] <= tpc_pkg::DIFF_W'($signed(i_item.verts[v][k]))
                                  - tpc_pkg::DIFF_W'($signed(i_p[k]));
                end
            end
        end
    end

    // stage 2: one product per coordinate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= r_s1;
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[v][k] <= $signed(i_n[k]) * r_diff[v][k];
                end
            end
        end
    end

    // stage 3: dot product sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s3.valid <= r_s2.valid;
            r_s3.verts <= r_s2.verts;
            r_s3.fill  <= r_s2.fill;
            r_s3.line  <= r_s2.line;
            for (int v = 0; v < 3; v++) begin
                r_s3.dval[v] <= tpc_pkg::DIST_W'(r_prod[v][0])
                              + tpc_pkg::DIST_W'(r_prod[v][1])
                              + tpc_pkg::DIST_W'(r_prod[v][2]);
            end
        end
    end

    assign o_item = r_s3;

endmodule

### sv/tpc_div_step.sv
// One restoring division step for both edge crossings, registered.
module tpc_div_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  tpc_pkg::t_dpipe  i_stage,
    output tpc_pkg::t_dpipe  o_stage
);

    tpc_pkg::t_dpipe r_stage;
    tpc_pkg::t_dpipe n_stage;

    function automatic tpc_pkg::t_div step(input tpc_pkg::t_div x);
        logic [tpc_pkg::REM_W-1:0] rem2;
        tpc_pkg::t_div             y;
        rem2 = {x.rem, 1'b0};
        y    = x;
        if (rem2 >= {1'b0, x.den}) begin
            y.rem = tpc_pkg::DIST_W'(rem2 - {1'b0, x.den});
            y.q   = {x.q[tpc_pkg::FRAC_W-2:0], 1'b1};
        end else begin
            y.rem = rem2[tpc_pkg::DIST_W-1:0];
            y.q   = {x.q[tpc_pkg::FRAC_W-2:0], 1'b0};
        end
        return y;
    endfunction

    always_comb begin
        n_stage    = i_stage;
        n_stage.d0 = step(i_stage.d0);
        n_stage.d1 = step(i_stage.d1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

### sv/tpc_lerp.sv
// Crossing points: scale edge deltas by the fraction, then round and offset.
module tpc_lerp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  tpc_pkg::t_dpipe  i_stage,
    output tpc_pkg::t_res    o_res
);

    localparam int SUM_W = tpc_pkg::LERP_W + 1;
    localparam int OFS_W = tpc_pkg::DIFF_W + 1;

    logic             r_a_valid;
    tpc_pkg::t_job    r_a_job;
    logic [tpc_pkg::LERP_W-1:0] r_prod0 [3];
    logic [tpc_pkg::LERP_W-1:0] r_prod1 [3];

    tpc_pkg::t_res    r_res;
    tpc_pkg::t_res    n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_stage.valid;
            r_a_job   <= i_stage.job;
            for (int k = 0; k < 3; k++) begin
                r_prod0[k] <= tpc_pkg::LERP_W'(i_stage.job.mag0[k]) *
                              tpc_pkg::LERP_W'(i_stage.d0.q);
                r_prod1[k] <= tpc_pkg::LERP_W'(i_stage.job.mag1[k]) *
                              tpc_pkg::LERP_W'(i_stage.d1.q);
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0]        sum0;
        logic [SUM_W-1:0]        sum1;
        logic [OFS_W-1:0]        ofs0;
        logic [OFS_W-1:0]        ofs1;
        logic signed [OFS_W-1:0] base0;
        logic signed [OFS_W-1:0] base1;
        logic signed [OFS_W-1:0] pos0;
        logic signed [OFS_W-1:0] pos1;
        n_res.valid = r_a_valid;
        n_res.ni    = r_a_job.ni;
        n_res.fill  = r_a_job.fill;
        n_res.line  = r_a_job.line;
        for (int k = 0; k < 3; k++) begin
            n_res.p0[k] = 32'($signed(r_a_job.p0[k]));
            n_res.p1[k] = 32'($signed(r_a_job.p1[k]));
            n_res.p2[k] = 32'($signed(r_a_job.p2[k]));
            // round half up at the binary point of the fraction
            sum0  = SUM_W'(r_prod0[k]) + (SUM_W'(1) << (tpc_pkg::FRAC_W - 1));
            sum1  = SUM_W'(r_prod1[k]) + (SUM_W'(1) << (tpc_pkg::FRAC_W - 1));
            ofs0  = sum0[SUM_W-1:tpc_pkg::FRAC_W];
            ofs1  = sum1[SUM_W-1:tpc_pkg::FRAC_W];
            base0 = OFS_W'($signed(r_a_job.a0[k]));
            base1 = OFS_W'($signed(r_a_job.a1[k]));
            pos0  = r_a_job.neg0[k] ? base0 - $signed(ofs0) : base0 + $signed(ofs0);
            pos1  = r_a_job.neg1[k] ? base1 - $signed(ofs1) : base1 + $signed(ofs1);
            n_res.x0[k] = 32'(pos0);
            n_res.x1[k] = 32'(pos1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### sv/triangle_plane_clipper.sv
// Top level of the triangle plane clipper: config, classify, divide chain, output.
//
// Clips one triangle per transfer against the plane through point P with normal
// N (need not be unit length); a vertex is inside when N.(V-P) >= 0. Each input
// gives zero, one or two output triangles carrying the input colors. The path
// runs through 3 distance stages, 1 classify stage, 32 restoring divide stages
// (one fraction bit per stage), 2 interpolation stages and the output register.
// A new triangle can be taken every cycle while busy is low; a triangle that
// clips into two results holds the whole pipeline while the output register
// takes its first result, and busy is high while it holds; the second result
// follows right after the first. Results appear on o_valid for exactly one
// cycle and cannot be held off. Config writes are always taken (ready is tied
// high) and should only be done while no triangle is in flight; writes to an
// index beyond the six plane registers are ignored.
module triangle_plane_clipper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [31:0]                     i_ax,
    input  logic [31:0]                     i_ay,
    input  logic [31:0]                     i_az,
    input  logic [31:0]                     i_bx,
    input  logic [31:0]                     i_by,
    input  logic [31:0]                     i_bz,
    input  logic [31:0]                     i_cx,
    input  logic [31:0]                     i_cy,
    input  logic [31:0]                     i_cz,
    input  logic [31:0]                     i_fill_color,
    input  logic [31:0]                     i_line_color,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output logic                            o_valid,
    output logic [31:0]                     o_out_ax,
    output logic [31:0]                     o_out_ay,
    output logic [31:0]                     o_out_az,
    output logic [31:0]                     o_out_bx,
    output logic [31:0]                     o_out_by,
    output logic [31:0]                     o_out_bz,
    output logic [31:0]                     o_out_cx,
    output logic [31:0]                     o_out_cy,
    output logic [31:0]                     o_out_cz,
    output logic [31:0]                     o_out_fill,
    output logic [31:0]                     o_out_line,
    output logic                            o_last_of_run
);

    // ---------------------------------------------------------------- config
    tpc_pkg::t_vec   r_p;
    tpc_pkg::t_vec32 r_n;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p    <= '0;
            r_n[0] <= '0;
            r_n[1] <= '0;
            r_n[2] <= tpc_pkg::NZ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tpc_pkg::CFG_PX: r_p[0] <= tpc_pkg::ext_coord(i_cfg_data);
                tpc_pkg::CFG_PY: r_p[1] <= tpc_pkg::ext_coord(i_cfg_data);
                tpc_pkg::CFG_PZ: r_p[2] <= tpc_pkg::ext_coord(i_cfg_data);
                tpc_pkg::CFG_NX: r_n[0] <= i_cfg_data;
                tpc_pkg::CFG_NY: r_n[1] <= i_cfg_data;
                tpc_pkg::CFG_NZ: r_n[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stall
    // Single global enable: the only hold is the first half of a two-result item.
    tpc_pkg::t_res res;
    logic          r_half;
    logic          stall;
    logic          en;

    assign stall  = res.valid && (res.ni == tpc_pkg::IN_TWO) && !r_half;
    assign en     = !stall;
    assign o_busy = stall;

    // ---------------------------------------------------------------- distance
    tpc_pkg::t_dist_in  dist_in;
    tpc_pkg::t_dist_out dist_out;

    always_comb begin
        dist_in.valid       = i_start && !o_busy;
        dist_in.verts[0][0] = tpc_pkg::ext_coord(i_ax);
        dist_in.verts[0][1] = tpc_pkg::ext_coord(i_ay);
        dist_in.verts[0][2] = tpc_pkg::ext_coord(i_az);
        dist_in.verts[1][0] = tpc_pkg::ext_coord(i_bx);
        dist_in.verts[1][1] = tpc_pkg::ext_coord(i_by);
        dist_in.verts[1][2] = tpc_pkg::ext_coord(i_bz);
        dist_in.verts[2][0] = tpc_pkg::ext_coord(i_cx);
        dist_in.verts[2][1] = tpc_pkg::ext_coord(i_cy);
        dist_in.verts[2][2] = tpc_pkg::ext_coord(i_cz);
        dist_in.fill        = i_fill_color;
        dist_in.line        = i_line_color;
    end

    tpc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (dist_in),
        .i_p     (r_p),
        .i_n     (r_n),
        .o_item  (dist_out)
    );

    // ---------------------------------------------------------------- classify
    // Pick the inside vertices i0, i1 and outside o0, o1 in input order.
    // Crossing 0 is edge (i0, o0); crossing 1 is (i0, o1) with one vertex
    // inside and (i1, o0) with two inside.
    tpc_pkg::t_dpipe r_sel;
    tpc_pkg::t_dpipe n_sel;

    always_comb begin
        logic [2:0]                       ins;
        logic [1:0]                       pi0;
        logic [1:0]                       pi1;
        logic [1:0]                       xa0;
        logic [1:0]                       xb0;
        logic [1:0]                       xa1;
        logic [1:0]                       xb1;
        logic signed [tpc_pkg::DIST_W:0]  df0;
        logic signed [tpc_pkg::DIST_W:0]  df1;
        logic signed [tpc_pkg::DIFF_W-1:0] dl0;
        logic signed [tpc_pkg::DIFF_W-1:0] dl1;
        for (int i = 0; i < 3; i++) begin
            ins[i] = !dist_out.dval[i][tpc_pkg::DIST_W-1];
        end
        pi0 = 2'd0; pi1 = 2'd1;
        xa0 = 2'd0; xb0 = 2'd1; xa1 = 2'd0; xb1 = 2'd2;
        case (ins)
            3'b001: begin pi0 = 2'd0; xa0 = 2'd0; xb0 = 2'd1; xa1 = 2'd0; xb1 = 2'd2; end
            3'b010: begin pi0 = 2'd1; xa0 = 2'd1; xb0 = 2'd0; xa1 = 2'd1; xb1 = 2'd2; end
            3'b100: begin pi0 = 2'd2; xa0 = 2'd2; xb0 = 2'd0; xa1 = 2'd2; xb1 = 2'd1; end
            3'b011: begin
                pi0 = 2'd0; pi1 = 2'd1; xa0 = 2'd0; xb0 = 2'd2; xa1 = 2'd1; xb1 = 2'd2;
            end
            3'b101: begin
                pi0 = 2'd0; pi1 = 2'd2; xa0 = 2'd0; xb0 = 2'd1; xa1 = 2'd2; xb1 = 2'd1;
            end
            3'b110: begin
                pi0 = 2'd1; pi1 = 2'd2; xa0 = 2'd1; xb0 = 2'd0; xa1 = 2'd2; xb1 = 2'd0;
            end
            default: ;
        endcase

        n_sel.valid    = dist_out.valid;
        n_sel.job.ni   = 2'(ins[0]) + 2'(ins[1]) + 2'(ins[2]);
        n_sel.job.p0   = dist_out.verts[pi0];
        n_sel.job.p1   = dist_out.verts[pi1];
        n_sel.job.p2   = dist_out.verts[2];
        n_sel.job.a0   = dist_out.verts[xa0];
        n_sel.job.a1   = dist_out.verts[xa1];
        n_sel.job.fill = dist_out.fill;
        n_sel.job.line = dist_out.line;
        for (int k = 0; k < 3; k++) begin
            dl0 = tpc_pkg::DIFF_W'($signed(dist_out.verts[xb0][k]))
                - tpc_pkg::DIFF_W'($signed(dist_out.verts[xa0][k]));
            dl1 = tpc_pkg::DIFF_W'($signed(dist_out.verts[xb1][k]))
                - tpc_pkg::DIFF_W'($signed(dist_out.verts[xa1][k]));
            n_sel.job.neg0[k] = dl0[tpc_pkg::DIFF_W-1];
            n_sel.job.neg1[k] = dl1[tpc_pkg::DIFF_W-1];
            n_sel.job.mag0[k] = dl0[tpc_pkg::DIFF_W-1] ? -dl0 : dl0;
            n_sel.job.mag1[k] = dl1[tpc_pkg::DIFF_W-1] ? -dl1 : dl1;
        end
        // t = d(in) / (d(in) - d(out)), remainder starts at d(in)
        df0 = (tpc_pkg::DIST_W+1)'($signed(dist_out.dval[xa0]))
            - (tpc_pkg::DIST_W+1)'($signed(dist_out.dval[xb0]));
        df1 = (tpc_pkg::DIST_W+1)'($signed(dist_out.dval[xa1]))
            - (tpc_pkg::DIST_W+1)'($signed(dist_out.dval[xb1]));
        n_sel.d0.den = df0[tpc_pkg::DIST_W-1:0];
        n_sel.d1.den = df1[tpc_pkg::DIST_W-1:0];
        n_sel.d0.rem = dist_out.dval[xa0];
        n_sel.d1.rem = dist_out.dval[xa1];
        n_sel.d0.q   = '0;
        n_sel.d1.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel.valid <= 1'b0;
        end else if (en) begin
            r_sel <= n_sel;
        end
    end

    // ---------------------------------------------------------------- divide
    tpc_pkg::t_dpipe chain [tpc_pkg::DIV_STEPS+1];

    assign chain[0] = r_sel;

    for (genvar g = 0; g < tpc_pkg::DIV_STEPS; g++) begin : g_div
        tpc_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    // ---------------------------------------------------------------- interpolate
    tpc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (chain[tpc_pkg::DIV_STEPS]),
        .o_res   (res)
    );

    // ---------------------------------------------------------------- output
    logic            r_o_valid;
    tpc_pkg::t_vec32 r_o_a;
    tpc_pkg::t_vec32 r_o_b;
    tpc_pkg::t_vec32 r_o_c;
    logic [31:0]     r_o_fill;
    logic [31:0]     r_o_line;
    logic            r_o_last;

    logic            n_o_valid;
    tpc_pkg::t_vec32 n_o_a;
    tpc_pkg::t_vec32 n_o_b;
    tpc_pkg::t_vec32 n_o_c;
    logic            n_o_last;

    always_comb begin
        n_o_valid = 1'b0;
        n_o_a     = res.p0;
        n_o_b     = res.p1;
        n_o_c     = res.p2;
        n_o_last  = 1'b1;
        if (res.valid) begin
            case (res.ni)
                tpc_pkg::IN_ALL: n_o_valid = 1'b1;
                tpc_pkg::IN_ONE: begin
                    n_o_valid = 1'b1;
                    n_o_b     = res.x0;
                    n_o_c     = res.x1;
                end
                tpc_pkg::IN_TWO: begin
                    n_o_valid = 1'b1;
                    if (!r_half) begin
                        n_o_c    = res.x0;
                        n_o_last = 1'b0;
                    end else begin
                        n_o_a = res.p1;
                        n_o_b = res.x0;
                        n_o_c = res.x1;
                    end
                end
                default: n_o_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_half    <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            r_half    <= stall;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_a    <= n_o_a;
        r_o_b    <= n_o_b;
        r_o_c    <= n_o_c;
        r_o_fill <= res.fill;
        r_o_line <= res.line;
        r_o_last <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_out_ax      = r_o_a[0];
    assign o_out_ay      = r_o_a[1];
    assign o_out_az      = r_o_a[2];
    assign o_out_bx      = r_o_b[0];
    assign o_out_by      = r_o_b[1];
    assign o_out_bz      = r_o_b[2];
    assign o_out_cx      = r_o_c[0];
    assign o_out_cy      = r_o_c[1];
    assign o_out_cz      = r_o_c[2];
    assign o_out_fill    = r_o_fill;
    assign o_out_line    = r_o_line;
    assign o_last_of_run = r_o_last;

    // ---------------------------------------------------------------- checks
    // a first half is always followed at once by its closing half
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |=> o_valid && o_last_of_run)
        else $error("second triangle of a split did not follow");

    // the hold for a split never lasts more than one cycle
    a_busy_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> !o_busy)
        else $error("busy held for more than one cycle");

    // while the second half is pending, the first half sits on the outputs
    a_half_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> o_valid && !o_last_of_run)
        else $error("pending second half without first half transfer");

endmodule
